/* design/phase_and_space_max_pool_assert.svh */
// Assertion macros shared by the pooling block.
`ifndef PHASE_AND_SPACE_MAX_POOL_ASSERT_SVH
`define PHASE_AND_SPACE_MAX_POOL_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PSMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/psmp_pkg.sv */
package psmp_pkg;

	localparam int MAX_KERNEL  = 4;
	localparam int MAX_PHASES  = 4;
	localparam int MAX_OUT_DIM = 64;
	localparam int MAX_IN_DIM  = 256;
	localparam int VALUE_BITS  = 16;
	localparam int WIN_DEPTH   = MAX_OUT_DIM * MAX_OUT_DIM;
	localparam int ENTRY_BITS  = VALUE_BITS + 64;

	// Register indexes
	localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd0;
	localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd1;
	localparam logic [2:0] REG_STRIDE        = 3'd2;
	localparam logic [2:0] REG_NUM_PHASES    = 3'd3;
	localparam logic [2:0] REG_IN_HEIGHT     = 3'd4;
	localparam logic [2:0] REG_IN_WIDTH      = 3'd5;
	localparam logic [2:0] REG_OUT_HEIGHT    = 3'd6;
	localparam logic [2:0] REG_OUT_WIDTH     = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ITER,
		ST_WR,
		ST_ADV
	} state_t;

	// Quotient of a small value by a stride of 1..4; thirds by reciprocal (x < 512)
	function automatic logic [8:0] div_stride(input logic [8:0] x, input logic [2:0] s);
		logic [17:0] prod;
		begin
			prod = {9'd0, x} * 18'd171;
			case (s)
				3'd1: return x;
				3'd2: return x >> 1;
				3'd3: return prod[17:9];
				default: return x >> 2;
			endcase
		end
	endfunction

	// Clamp a 3-bit register to 1..4
	function automatic logic [2:0] clamp_small(input logic [2:0] v);
		begin
			if (v == 3'd0) return 3'd1;
			if (v > 3'd4) return 3'd4;
			return v;
		end
	endfunction

endpackage

/* design/phase_and_space_max_pool.sv */
// Phase-and-space max pooling with tie masks. Samples arrive one band at a time, phase plane
// by phase plane, each plane in raster order; s_tuser marks the first sample of a band. Each
// window's running maximum and 64-bit tie mask live in one 4096-entry synchronous RAM, and
// every sample is folded into each window that covers it by a read, then a write, of that
// entry. Each sample takes a setup step, then a walk over the window rows and the candidate
// windows in each, with a read and a merge write per covering window, then an advance step.
// A finished window leaves in an output register, so the next sample is taken while it
// waits; only a second finished window before the first is taken stalls the block. The RAM
// needs no clearing after reset.
module phase_and_space_max_pool
	import psmp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] activity
	input  logic         s_tuser,   // band_start
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // [15:0] pooled_value, [79:16] tie_mask, [85:80] out_row,
	                                // [91:86] out_col, [95:92] zero
	output logic         m_tlast,   // band_done
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [8:0]   cfg_data
);

`include "phase_and_space_max_pool_assert.svh"

	state_t state_q, state_d;

	logic [2:0] kh_reg_q, kw_reg_q, stride_reg_q, np_reg_q;
	logic [8:0] ih_reg_q, iw_reg_q;
	logic [6:0] oh_reg_q, ow_reg_q;

	logic [2:0] kh, kw, s, np;
	logic [8:0] ih, iw;
	logic [6:0] oh, ow;

	logic [1:0] phase_q;
	logic [7:0] row_q, col_q;
	logic [15:0] act_q;

	logic [3:0] kj_q, ki_q, ki0_q;
	logic signed [8:0] top_q, left_q, left0_q;

	logic ram_re, ram_we;
	logic [11:0] ram_addr;
	logic [ENTRY_BITS-1:0] ram_rdata, ram_wdata;

	logic out_valid_q;
	logic [15:0] out_val_q;
	logic [63:0] out_ties_q;
	logic [5:0] out_row_q, out_col_q;
	logic out_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_reg_q     <= 3'd2;
			kw_reg_q     <= 3'd2;
			stride_reg_q <= 3'd2;
			np_reg_q     <= 3'd1;
			ih_reg_q     <= 9'd256;
			iw_reg_q     <= 9'd256;
			oh_reg_q     <= 7'd64;
			ow_reg_q     <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KERNEL_HEIGHT: kh_reg_q     <= cfg_data[2:0];
				REG_KERNEL_WIDTH:  kw_reg_q     <= cfg_data[2:0];
				REG_STRIDE:        stride_reg_q <= cfg_data[2:0];
				REG_NUM_PHASES:    np_reg_q     <= cfg_data[2:0];
				REG_IN_HEIGHT:     ih_reg_q     <= cfg_data;
				REG_IN_WIDTH:      iw_reg_q     <= cfg_data;
				REG_OUT_HEIGHT:    oh_reg_q     <= cfg_data[6:0];
				REG_OUT_WIDTH:     ow_reg_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Effective geometry after clamping and fitting
	logic [8:0] fit_h, fit_w;
	logic [6:0] oh_c, ow_c;
	always_comb begin
		kh = clamp_small(kh_reg_q);
		kw = clamp_small(kw_reg_q);
		s  = clamp_small(stride_reg_q);
		np = clamp_small(np_reg_q);
		ih = (ih_reg_q == 9'd0) ? 9'd1 : ((ih_reg_q > 9'd256) ? 9'd256 : ih_reg_q);
		iw = (iw_reg_q == 9'd0) ? 9'd1 : ((iw_reg_q > 9'd256) ? 9'd256 : iw_reg_q);
		oh_c = (oh_reg_q == 7'd0) ? 7'd1 : ((oh_reg_q > 7'd64) ? 7'd64 : oh_reg_q);
		ow_c = (ow_reg_q == 7'd0) ? 7'd1 : ((ow_reg_q > 7'd64) ? 7'd64 : ow_reg_q);
		fit_h = div_stride(ih - {6'd0, kh}, s);
		fit_w = div_stride(iw - {6'd0, kw}, s);
		if (ih < {6'd0, kh}) begin
			oh = 7'd0;
		end else if ({2'd0, oh_c} <= fit_h) begin
			oh = oh_c;
		end else begin
			oh = fit_h[6:0] + 7'd1;
		end
		if (iw < {6'd0, kw}) begin
			ow = 7'd0;
		end else if ({2'd0, ow_c} <= fit_w) begin
			ow = ow_c;
		end else begin
			ow = fit_w[6:0] + 7'd1;
		end
	end

	// Window walk decode
	logic row_end, col_end, in_range, emit, first_elem, out_busy;
	logic [7:0] bit_idx;
	logic [7:0] top_div, left_div;
	logic [8:0] top_quo, left_quo;
	always_comb begin
		row_end  = (kj_q >= {1'b0, kh}) || top_q[8];
		col_end  = (ki_q >= {1'b0, kw}) || left_q[8];
		in_range = (top_q[7:0] < {1'b0, oh}) && (left_q[7:0] < {1'b0, ow});
		emit = ({1'b0, phase_q} == np - 3'd1) && (kj_q == {1'b0, kh} - 4'd1)
			&& (ki_q == {1'b0, kw} - 4'd1);
		first_elem = (phase_q == 2'd0) && (kj_q == 4'd0) && (ki_q == 4'd0);
		bit_idx = {6'd0, phase_q} * ({5'd0, kh} * {5'd0, kw})
			+ {4'd0, kj_q} * {5'd0, kw} + {4'd0, ki_q};
		out_busy = out_valid_q && !m_tready;
		top_quo  = div_stride({1'b0, row_q}, s);
		left_quo = div_stride({1'b0, col_q}, s);
		top_div  = top_quo[7:0];
		left_div = left_quo[7:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_ITER;
			ST_ITER: begin
				if (row_end) begin
					state_d = ST_ADV;
				end else if (!col_end && in_range) begin
					state_d = ST_WR;
				end
			end
			ST_WR:    if (!(emit && out_busy)) state_d = ST_ITER;
			ST_ADV:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory strobes
	always_comb begin
		s_tready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_ITER: ram_re = !row_end && !col_end && in_range;
			ST_WR:   ram_we = !(emit && out_busy);
			default: ;
		endcase
	end

	// Merge the sample into the window entry
	logic signed [15:0] old_max, new_max;
	logic [63:0] old_ties, new_ties, bit_mask;
	always_comb begin
		old_max  = ram_rdata[15:0];
		old_ties = ram_rdata[ENTRY_BITS-1:16];
		bit_mask = 64'd1 << bit_idx[5:0];
		new_max  = old_max;
		new_ties = old_ties;
		if (first_elem || $signed(act_q) > old_max) begin
			new_max  = act_q;
			new_ties = bit_mask;
		end else if ($signed(act_q) == old_max) begin
			new_ties = old_ties | bit_mask;
		end
		ram_wdata = {new_ties, new_max};
		ram_addr  = {top_q[5:0], left_q[5:0]};
	end

	psmp_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(WIN_DEPTH)
	) u_win_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// State and position counters
	logic [8:0] col_inc, row_inc;
	logic [2:0] phase_inc;
	always_comb begin
		col_inc   = {1'b0, col_q} + 9'd1;
		row_inc   = {1'b0, row_q} + 9'd1;
		phase_inc = {1'b0, phase_q} + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			row_q   <= 8'd0;
			col_q   <= 8'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && s_tvalid && s_tuser) begin
				phase_q <= 2'd0;
				row_q   <= 8'd0;
				col_q   <= 8'd0;
			end else if (state_q == ST_ADV) begin
				if (col_inc >= iw) begin
					col_q <= 8'd0;
					if (row_inc >= ih) begin
						row_q   <= 8'd0;
						phase_q <= (phase_inc >= np) ? 2'd0 : phase_inc[1:0];
					end else begin
						row_q <= row_inc[7:0];
					end
				end else begin
					col_q <= col_inc[7:0];
				end
			end
		end
	end

	// Walk registers: first covering window, then step by stride
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: act_q <= s_tdata;
			ST_SETUP: begin
				kj_q    <= {2'd0, row_q[1:0] - 2'(top_div * {5'd0, s})};
				ki_q    <= {2'd0, col_q[1:0] - 2'(left_div * {5'd0, s})};
				ki0_q   <= {2'd0, col_q[1:0] - 2'(left_div * {5'd0, s})};
				top_q   <= {1'b0, top_div};
				left_q  <= {1'b0, left_div};
				left0_q <= {1'b0, left_div};
			end
			ST_ITER: begin
				if (!row_end) begin
					if (col_end) begin
						kj_q   <= kj_q + {1'b0, s};
						top_q  <= top_q - 9'sd1;
						ki_q   <= ki0_q;
						left_q <= left0_q;
					end else if (!in_range) begin
						ki_q   <= ki_q + {1'b0, s};
						left_q <= left_q - 9'sd1;
					end
				end
			end
			ST_WR: begin
				if (!(emit && out_busy)) begin
					ki_q   <= ki_q + {1'b0, s};
					left_q <= left_q - 9'sd1;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WR && emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR && emit && !out_busy) begin
			out_val_q  <= new_max;
			out_ties_q <= new_ties;
			out_row_q  <= top_q[5:0];
			out_col_q  <= left_q[5:0];
			out_last_q <= (top_q[7:0] == {1'b0, oh} - 8'd1)
				&& (left_q[7:0] == {1'b0, ow} - 8'd1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_col_q, out_row_q, out_ties_q, out_val_q};
	assign m_tlast  = out_last_q;

	`PSMP_ASSERT_NEXT(a_read_then_merge, ram_re, state_q == ST_WR, "read not followed by merge")
	`PSMP_ASSERT_NEXT(a_hold_on_full, state_q == ST_WR && emit && out_busy, state_q == ST_WR && m_tvalid, "merge left while output full")
	`PSMP_ASSERT_NOW(a_no_write_in_walk, ram_we, state_q == ST_WR && !(emit && out_busy), "stray window write")

endmodule

/* design/psmp_ram.sv */
module psmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* test/phase_and_space_max_pool_test.sv */
`default_nettype none

module phase_and_space_max_pool_test;
	import psmp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic signed [15:0] value;
		logic [63:0]        ties;
		logic [5:0]         row;
		logic [5:0]         col;
		logic               done;
	} pooled_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] activity
	logic        s_tuser;   // band_start
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // [15:0] value, [79:16] ties, [85:80] row, [91:86] col, [95:92] zero
	logic        m_tlast;   // band_done
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;

	// Predictor state
	int unsigned        pool_reg [8];
	logic signed [15:0] win_max [WIN_DEPTH];
	logic [63:0]        win_ties [WIN_DEPTH];
	int unsigned        cur_phase, cur_row, cur_col;

	pooled_t     pooled_q [$];
	int          errors;
	int          items_sent;
	int unsigned cycles;
	bit          quiet;
	bit          rx_hold_req;
	int          rx_hold_left;
	int          rx_idle;

	phase_and_space_max_pool dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned windows_fitting(int unsigned r, int unsigned in_dim,
			int unsigned k, int unsigned s);
		int unsigned o;
		int unsigned fit;
		o = clamp_range(r, 1, MAX_OUT_DIM);
		if (in_dim < k) return 0;
		fit = (in_dim - k) / s + 1;
		return (o < fit) ? o : fit;
	endfunction

	// Fold one accepted sample into every covering window; queue a finished one
	function automatic void pool_sample(logic signed [15:0] v, logic start);
		int unsigned kh, kw, s, np, ih, iw, oh, ow, top, left, idx, bitpos;
		int unsigned p, r, c;
		logic [63:0] b;
		pooled_t res;
		kh = clamp_range(pool_reg[REG_KERNEL_HEIGHT], 1, MAX_KERNEL);
		kw = clamp_range(pool_reg[REG_KERNEL_WIDTH], 1, MAX_KERNEL);
		s  = clamp_range(pool_reg[REG_STRIDE], 1, MAX_KERNEL);
		np = clamp_range(pool_reg[REG_NUM_PHASES], 1, MAX_PHASES);
		ih = clamp_range(pool_reg[REG_IN_HEIGHT], 1, MAX_IN_DIM);
		iw = clamp_range(pool_reg[REG_IN_WIDTH], 1, MAX_IN_DIM);
		oh = windows_fitting(pool_reg[REG_OUT_HEIGHT], ih, kh, s);
		ow = windows_fitting(pool_reg[REG_OUT_WIDTH], iw, kw, s);
		if (start) begin
			cur_phase = 0;
			cur_row = 0;
			cur_col = 0;
		end
		p = cur_phase;
		r = cur_row;
		c = cur_col;
		for (int unsigned kj = 0; kj < kh; kj++) begin
			if (r < kj || (r - kj) % s != 0) continue;
			top = (r - kj) / s;
			if (top >= oh) continue;
			for (int unsigned ki = 0; ki < kw; ki++) begin
				if (c < ki || (c - ki) % s != 0) continue;
				left = (c - ki) / s;
				if (left >= ow) continue;
				idx = (top * MAX_OUT_DIM + left) % WIN_DEPTH;
				bitpos = (p * kh * kw + kj * kw + ki) & 63;
				b = 64'd1 << bitpos;
				if ((p == 0 && kj == 0 && ki == 0) || v > win_max[idx]) begin
					win_max[idx] = v;
					win_ties[idx] = b;
				end else if (v == win_max[idx]) begin
					win_ties[idx] |= b;
				end
				if (p == np - 1 && kj == kh - 1 && ki == kw - 1) begin
					res.value = win_max[idx];
					res.ties = win_ties[idx];
					res.row = top[5:0];
					res.col = left[5:0];
					res.done = (top == oh - 1 && left == ow - 1);
					pooled_q.push_back(res);
				end
			end
		end
		cur_col = c + 1;
		if (cur_col >= iw) begin
			cur_col = 0;
			cur_row = r + 1;
			if (cur_row >= ih) begin
				cur_row = 0;
				cur_phase = p + 1;
				if (cur_phase >= np) cur_phase = 0;
			end
		end
	endfunction

	function automatic int gap_length();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one sample and hold it until the transaction completes
	task automatic send_sample(logic [15:0] v, logic start);
		int n;
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= start;
		do
			@(posedge clk);
		while (!s_tready);
		pool_sample(v, start);
		items_sent++;
		n = gap_length();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait for every expected window, then let any work in flight finish
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pooled_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, int unsigned value);
		logic [8:0] masked;
		masked = value[8:0];
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= masked;
		@(posedge clk);
		case (index)
			REG_IN_HEIGHT, REG_IN_WIDTH:   pool_reg[index] = masked;
			REG_OUT_HEIGHT, REG_OUT_WIDTH: pool_reg[index] = masked[6:0];
			default:                       pool_reg[index] = masked[2:0];
		endcase
	endtask

	task automatic set_shape(int unsigned kh, int unsigned kw, int unsigned s, int unsigned np,
			int unsigned ih, int unsigned iw, int unsigned oh, int unsigned ow);
		drain();
		write_reg(REG_KERNEL_HEIGHT, kh);
		write_reg(REG_KERNEL_WIDTH, kw);
		write_reg(REG_STRIDE, s);
		write_reg(REG_NUM_PHASES, np);
		write_reg(REG_IN_HEIGHT, ih);
		write_reg(REG_IN_WIDTH, iw);
		write_reg(REG_OUT_HEIGHT, oh);
		write_reg(REG_OUT_WIDTH, ow);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] random_activity();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return 16'($signed($urandom_range(0, 6)) - 3);
		if (r == 4) return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
		return 16'($urandom);
	endfunction

	// Send one band, flagged at its first sample and now and then at a random later one; optionally cut it short
	task automatic send_band(bit truncate);
		int unsigned np, ih, iw, total;
		np = clamp_range(pool_reg[REG_NUM_PHASES], 1, MAX_PHASES);
		ih = clamp_range(pool_reg[REG_IN_HEIGHT], 1, MAX_IN_DIM);
		iw = clamp_range(pool_reg[REG_IN_WIDTH], 1, MAX_IN_DIM);
		total = np * ih * iw;
		if (truncate) total = $urandom_range(1, total);
		for (int unsigned i = 0; i < total; i++)
			send_sample(random_activity(), i == 0 || $urandom_range(0, 199) == 0);
	endtask

	task automatic test_reset_shape();
		// reset shape: 2x2 windows, stride 2, 256x256 plane; first rows only
		for (int i = 0; i < 780; i++)
			send_sample(16'($urandom), i == 0);
	endtask

	task automatic test_extremes();
		// full 4x4x4 window of equal values gives an all-ones tie mask
		set_shape(4, 4, 1, 4, 4, 4, 64, 64);
		for (int i = 0; i < 64; i++) send_sample(16'h7fff, i == 0);
		// most negative everywhere but one larger sample
		for (int i = 0; i < 64; i++) send_sample((i == 37) ? 16'h8001 : 16'h8000, i == 0);
	endtask

	task automatic test_saturation();
		// kernel 0 -> 1, stride 7 -> 4, phases 0 -> 1, planes 0 -> 1 and 511 -> 256
		set_shape(0, 7, 7, 0, 511, 0, 127, 0);
		send_band(1'b0);
		set_shape(5, 6, 0, 7, 3, 5, 0, 127);
		send_band(1'b0);
		// kernel taller than the plane: no window at all
		set_shape(4, 2, 1, 2, 2, 6, 8, 8);
		send_band(1'b0);
		// restart a band partway through
		set_shape(2, 3, 1, 2, 3, 4, 64, 64);
		send_band(1'b1);
		send_band(1'b0);
	endtask

	task automatic test_backpressure();
		set_shape(1, 1, 1, 1, 8, 8, 64, 64);
		quiet = 1'b1;
		rx_hold_req = 1'b1;
		send_band(1'b0);
		send_band(1'b0);
		quiet = 1'b0;
		drain();
		send_band(1'b0);
	endtask

	task automatic test_random();
		int unsigned kh, kw, s;
		while (items_sent < 1800) begin
			kh = $urandom_range(1, 4);
			kw = $urandom_range(1, 4);
			s = $urandom_range(1, 4);
			set_shape(kh, kw, s, $urandom_range(1, 4),
				$urandom_range(kh > 1 ? kh - 1 : 1, kh + 7),
				$urandom_range(kw > 1 ? kw - 1 : 1, kw + 7),
				($urandom_range(0, 4) == 0) ? 127 : $urandom_range(1, 6),
				($urandom_range(0, 4) == 0) ? 127 : $urandom_range(1, 6));
			quiet = ($urandom_range(0, 5) == 0);
			repeat ($urandom_range(1, 3)) send_band($urandom_range(0, 9) == 0);
			quiet = 1'b0;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req <= 1'b0;
			rx_hold_left <= 400;
			m_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_idle > 0) begin
			rx_idle <= rx_idle - 1;
			m_tready <= 1'b0;
		end else begin
			rx_idle <= gap_length();
			m_tready <= 1'b1;
		end
	end

	// Compare each window transaction with the oldest expectation
	always @(posedge clk) begin
		pooled_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pooled_q.size() == 0) begin
				$display("%0t: unexpected window, actual %h last %b", $realtime, m_tdata, m_tlast);
				errors++;
			end else begin
				want = pooled_q.pop_front();
				if (m_tdata[15:0] !== want.value) begin
					$display("%0t: value expected %h actual %h", $realtime, want.value,
						m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[79:16] !== want.ties) begin
					$display("%0t: ties expected %h actual %h", $realtime, want.ties,
						m_tdata[79:16]);
					errors++;
				end
				if (m_tdata[85:80] !== want.row) begin
					$display("%0t: row expected %0d actual %0d", $realtime, want.row,
						m_tdata[85:80]);
					errors++;
				end
				if (m_tdata[91:86] !== want.col) begin
					$display("%0t: col expected %0d actual %0d", $realtime, want.col,
						m_tdata[91:86]);
					errors++;
				end
				if (m_tlast !== want.done) begin
					$display("%0t: last expected %b actual %b", $realtime, want.done, m_tlast);
					errors++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("phase_and_space_max_pool_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		quiet = 1'b0;
		rx_hold_req = 1'b0;
		rx_hold_left = 0;
		rx_idle = 0;
		pool_reg = '{2, 2, 2, 1, 256, 256, 64, 64};
		cur_phase = 0;
		cur_row = 0;
		cur_col = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_shape();
		test_extremes();
		test_saturation();
		test_backpressure();
		test_random();
		drain();

		if (errors == 0) begin
			$display("phase_and_space_max_pool_test: PASS");
		end else begin
			$display("phase_and_space_max_pool_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
